// ===== design/spd_pkg.sv =====
`default_nettype none
package spd_pkg;
    localparam int TOTAL_BITS = 30;
    localparam int COUNT_BITS = 11;
    localparam int SUM_BITS   = 33;
endpackage
`default_nettype wire

// ===== design/spd_ram.sv =====
`default_nettype none
module spd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/spd_insert.sv =====
`default_nettype none
module spd_insert #(
    parameter int VALUE_BITS = 20,
    parameter int MAX_PAIRS  = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [VALUE_BITS-1:0]        value,
    input  wire logic [$clog2(MAX_PAIRS)-1:0] count,
    input  wire logic [$clog2(MAX_PAIRS)-1:0] ext_addr,
    output logic      [VALUE_BITS-1:0]        rdata,
    output logic                              busy
);
    localparam int IW = $clog2(MAX_PAIRS);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_PUT} state_t;

    state_t                state_reg, state_next;
    logic [IW-1:0]         pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  we;
    logic [IW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [IW-1:0]         raddr;

    spd_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PAIRS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = val_reg;
        raddr      = ext_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    val_next = value;
                    pos_next = count;
                    raddr    = count - IW'(1);
                    state_next = (count == '0) ? S_PUT : S_CMP;
                end
            end
            S_CMP:
            begin
                raddr = pos_reg - IW'(2);
                if (rdata > val_reg)
                begin
                    we       = 1'b1;
                    wdata    = rdata;
                    pos_next = pos_reg - IW'(1);
                    if (pos_reg == IW'(1))
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
    end
endmodule
`default_nettype wire

// ===== design/sorted_pair_distance_sum.sv =====
`default_nettype none
// Each item is a left/right value pair, taken when start is high and busy is low.
// Each list is kept sorted in its own memory: a pair is inserted by shifting larger
// entries up one place in a read-compare-write loop over the memory port. A pair
// marked last is inserted, then both memories are read by rank, one entry per cycle,
// and the absolute differences summed. The result shows on done for exactly one
// cycle and must be taken then; the block is busy until it appears. Pairs past
// MAX_PAIRS are dropped and flagged.
module sorted_pair_distance_sum #(
    parameter int MAX_PAIRS  = 1024,
    parameter int VALUE_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [VALUE_BITS-1:0] right_value,
    input  wire logic                  last_pair,
    output logic                       done,
    output logic [spd_pkg::TOTAL_BITS-1:0] total_distance,
    output logic [spd_pkg::COUNT_BITS-1:0] pairs_used,
    output logic                       dropped_flag
);
    localparam int IW = $clog2(MAX_PAIRS);
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int TB = spd_pkg::TOTAL_BITS;
    localparam int SB = spd_pkg::SUM_BITS;
    localparam int NB = spd_pkg::COUNT_BITS;

    typedef enum logic [1:0] {S_IDLE, S_INS, S_SUM} state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            last_reg, last_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            pend_reg, pend_next;
    logic [TB-1:0]   acc_reg, acc_next;
    logic            done_reg, done_next;
    logic [TB-1:0]   tot_reg, tot_next;
    logic [NB-1:0]   used_reg, used_next;
    logic            drop_reg, drop_next;

    logic                  go;
    logic                  lbusy, rbusy;
    logic [VALUE_BITS-1:0] lrd, rrd, diff;
    logic [SB-1:0]         sum_wide;
    logic [CW+NB-1:0]      count_ext;

    assign go = (state_reg == S_IDLE) && start && (count_reg < CW'(MAX_PAIRS));

    spd_insert #(.VALUE_BITS(VALUE_BITS), .MAX_PAIRS(MAX_PAIRS)) u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .value    (left_value),
        .count    (count_reg[IW-1:0]),
        .ext_addr (k_reg[IW-1:0]),
        .rdata    (lrd),
        .busy     (lbusy)
    );

    spd_insert #(.VALUE_BITS(VALUE_BITS), .MAX_PAIRS(MAX_PAIRS)) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .value    (right_value),
        .count    (count_reg[IW-1:0]),
        .ext_addr (k_reg[IW-1:0]),
        .rdata    (rrd),
        .busy     (rbusy)
    );

    assign diff      = (lrd > rrd) ? (lrd - rrd) : (rrd - lrd);
    assign sum_wide  = SB'(acc_reg) + SB'(diff);
    assign count_ext = {{NB{1'b0}}, count_reg};

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign total_distance = tot_reg;
    assign pairs_used     = used_reg;
    assign dropped_flag   = drop_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        last_next  = last_reg;
        k_next     = k_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        tot_next   = tot_reg;
        used_next  = used_reg;
        drop_next  = drop_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next = last_pair;
                    k_next    = '0;
                    acc_next  = '0;
                    if (go)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (last_pair)
                        begin
                            state_next = S_SUM;
                        end
                    end
                end
            end
            S_INS:
            begin
                if (!lbusy && !rbusy)
                begin
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? S_SUM : S_IDLE;
                end
            end
            S_SUM:
            begin
                if (pend_reg)
                begin
                    acc_next = (sum_wide > SB'({TB{1'b1}})) ? {TB{1'b1}} : sum_wide[TB-1:0];
                end
                if (k_reg < count_reg)
                begin
                    k_next    = k_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    done_next  = 1'b1;
                    tot_next   = acc_reg;
                    used_next  = count_ext[NB-1:0];
                    drop_next  = ovf_reg;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        tot_reg  <= tot_next;
        used_reg <= used_next;
        drop_reg <= drop_next;
    end
endmodule
`default_nettype wire
